[rtl/core/wavetable_oscillator_macros.svh]
// ----------------------------------------------------------------------------
// Wavetable oscillator assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_MACROS_SVH
`define WAVETABLE_OSCILLATOR_MACROS_SVH

// Check that is switched off while reset is asserted
`define WTO_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs through reset
`define WTO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/wto_pkg.sv]
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Shared constants, request codes and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package wto_pkg;

  // Default sizes
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int REQ_W       = 2;
  localparam int IDX_FIELD_W = 5;
  localparam int PHASE_W     = 16;
  localparam int STEP_W      = 21;

  // Phase step after reset
  localparam logic [STEP_W-1:0] STEP_RESET = 21'd19223;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PHASE = 2'd2;

  // Phase unit control for one accepted beat
  typedef struct packed {
    logic tick;
    logic phase_ld;
  } wto_ctl_t;

endpackage

`default_nettype wire

[rtl/core/wto_if.sv]
// ----------------------------------------------------------------------------
// Wavetable oscillator channels
// Valid/ready channels for requests, samples and the phase step register.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel
interface wto_in_if
  import wto_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic        [REQ_W-1:0]       req_type;
  logic        [IDX_FIELD_W-1:0] table_index;
  logic signed [SAMPLE_BITS-1:0] table_value;
  logic        [PHASE_W-1:0]     phase_value;

  modport source (output valid, req_type, table_index, table_value, phase_value,
                  input ready);
  modport sink   (input valid, req_type, table_index, table_value, phase_value,
                  output ready);
endinterface

// Sample channel
interface wto_out_if
  import wto_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

// Phase step write channel
interface wto_cfg_if
  import wto_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] phase_step;

  modport source (output valid, phase_step, input ready);
  modport sink   (input valid, phase_step, output ready);
endinterface

`default_nettype wire

[rtl/core/wavetable_oscillator.sv]
// ----------------------------------------------------------------------------
// Wavetable oscillator
// Linear-interpolating single-cycle wavetable oscillator, top level.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests: a tick makes one sample, a table write stores
//   table_value at table_index, a phase set loads phase_value as a fraction
//   of a cycle. Writes, phase sets and the unused code give no beat on out_ch.
//   out_ch carries one interpolated Q1.15 sample per tick, in request order.
//   cfg_ch writes the phase step; write it only while the block is idle.
//   cfg_ch is always ready.
// Timing:
//   One request is taken every cycle unless a stall drops in_ch.ready. A
//   tick's sample takes this path to out_ch: the registered two-port table
//   read happens as the tick is taken, then the multiply-add blend loads the
//   sample register. The read addresses come straight from the phase
//   register, so a table write is seen by a tick taken in the very next cycle.
// Reset:
//   rst_n clears the phase to zero, loads the default phase step and
//   empties the pipeline. Table contents are undefined until written.
// Stalls:
//   While out_ch stalls, the sample register and the read stage hold; once
//   both are full in_ch.ready drops until the sink takes the waiting sample.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_oscillator
  import wto_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wto_in_if.sink     in_ch,
  wto_out_if.source  out_ch,
  wto_cfg_if.sink    cfg_ch
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic                          in_take;
  logic                          in_beat;
  logic                          tbl_we;
  wto_ctl_t                      ctl;
  logic        [ADDR_W-1:0]      rd_idx0;
  logic        [ADDR_W-1:0]      rd_idx1;
  logic        [FRAC_BITS-1:0]   frac;
  logic signed [SAMPLE_BITS-1:0] s0;
  logic signed [SAMPLE_BITS-1:0] s1;

  // Request decode
  assign in_ch.ready  = in_take;
  assign in_beat      = in_ch.valid && in_take;
  assign ctl.tick     = in_beat && (in_ch.req_type == REQ_TICK);
  assign ctl.phase_ld = in_beat && (in_ch.req_type == REQ_PHASE);
  assign tbl_we       = in_beat && (in_ch.req_type == REQ_WRITE);

  assign cfg_ch.ready = 1'b1;

  // Phase accumulator and step register
  wto_phase #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_ch.valid),
    .cfg_step    (cfg_ch.phase_step),
    .ctl         (ctl),
    .phase_value (in_ch.phase_value),
    .rd_idx0     (rd_idx0),
    .rd_idx1     (rd_idx1),
    .frac        (frac)
  );

  // Wave table
  wto_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (ADDR_W'(in_ch.table_index)),
    .wdata   (in_ch.table_value),
    .re      (ctl.tick),
    .raddr_a (rd_idx0),
    .raddr_b (rd_idx1),
    .rdata_a (s0),
    .rdata_b (s1)
  );

  // Interpolation and sample register
  wto_blend #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ctl.tick),
    .frac_in    (frac),
    .s0         (s0),
    .s1         (s1),
    .take       (in_take),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.sample)
  );

endmodule

`default_nettype wire

[rtl/core/wto_ram.sv]
// ----------------------------------------------------------------------------
// Wavetable RAM
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module wto_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [WIDTH-1:0]  rdata_a,
  output logic      [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[rtl/core/wto_phase.sv]
// ----------------------------------------------------------------------------
// Wavetable phase accumulator
// Holds the phase step register and the phase, makes the two read indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module wto_phase
  import wto_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [STEP_W-1:0]    cfg_step,
  input  wire wto_ctl_t             ctl,
  input  wire logic [PHASE_W-1:0]   phase_value,
  output logic      [ADDR_W-1:0]    rd_idx0,
  output logic      [ADDR_W-1:0]    rd_idx1,
  output logic      [FRAC_BITS-1:0] frac
);

  localparam int ACC_W = ADDR_W + FRAC_BITS;
  localparam int SUM_W = (ACC_W > STEP_W) ? ACC_W : STEP_W;

  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [SUM_W-1:0]         acc_sum;
  logic [PHASE_W+ACC_W-1:0] phase_scaled;

  // Step add wraps modulo the table length
  assign acc_sum = SUM_W'(acc_r) + SUM_W'(step_r);

  // phase_value * depth, scaled from 16 to FRAC_BITS fraction bits
  assign phase_scaled = {phase_value, {ACC_W{1'b0}}};

  always_comb begin
    step_nxt = cfg_we ? cfg_step : step_r;
    acc_nxt  = acc_r;
    if (ctl.tick) begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end else if (ctl.phase_ld) begin
      acc_nxt = phase_scaled[PHASE_W+ACC_W-1:PHASE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      acc_r  <= '0;
    end else begin
      step_r <= step_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // Current entry, its neighbor (wrapping) and the blend fraction
  assign rd_idx0 = acc_r[ACC_W-1:FRAC_BITS];
  assign rd_idx1 = rd_idx0 + ADDR_W'(1);
  assign frac    = acc_r[FRAC_BITS-1:0];

endmodule

`default_nettype wire

[rtl/core/wto_blend.sv]
// ----------------------------------------------------------------------------
// Wavetable blend stage
// Linear interpolation between two table entries and the sample register.
// ----------------------------------------------------------------------------
`default_nettype none

module wto_blend
  import wto_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic        [FRAC_BITS-1:0]   frac_in,
  input  wire logic signed [SAMPLE_BITS-1:0] s0,
  input  wire logic signed [SAMPLE_BITS-1:0] s1,
  output logic                               take,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [SAMPLE_BITS-1:0] out_sample
);

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int BL_W   = SAMPLE_BITS + FRAC_BITS + 2;

  logic                          rd_valid_r, rd_valid_nxt;
  logic        [FRAC_BITS-1:0]   frac_r, frac_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic                          adv;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [BL_W-1:0]        prod;
  logic signed [BL_W-1:0]        blend_sum;
  logic signed [BL_W-1:0]        blend_q;

  // Handshake: output register frees the read stage
  assign adv  = !out_valid_r || out_ready;
  assign take = !rd_valid_r || adv;

  // floor((s0 * 2^F + (s1 - s0) * f) / 2^F)
  assign diff      = DIFF_W'(s1) - DIFF_W'(s0);
  assign frac_s    = $signed({1'b0, frac_r});
  assign prod      = diff * frac_s;
  assign blend_sum = (BL_W'(s0) <<< FRAC_BITS) + prod;
  assign blend_q   = blend_sum >>> FRAC_BITS;

  always_comb begin
    rd_valid_nxt  = take ? load : rd_valid_r;
    frac_nxt      = load ? frac_in : frac_r;
    out_valid_nxt = adv ? rd_valid_r : out_valid_r;
    sample_nxt    = (adv && rd_valid_r) ? blend_q[SAMPLE_BITS-1:0] : sample_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    frac_r   <= frac_nxt;
    sample_r <= sample_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;

endmodule

`default_nettype wire

[rtl/core/wto_checker.sv]
// ----------------------------------------------------------------------------
// Wavetable oscillator port checker
// Concurrent checks on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wavetable_oscillator_macros.svh"

module wto_checker
  import wto_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic [REQ_W-1:0]       in_req_type,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] out_sample
);

  logic tick_beat;

  assign tick_beat = in_valid && in_ready && (in_req_type == REQ_TICK);

  // Pipeline is empty right after reset
  `WTO_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "sample valid after reset")

  // A stalled sample stays put
  `WTO_ASSERT_RUN(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_sample), "stalled sample changed")

  // Requests are taken whenever the sample register is empty
  `WTO_ASSERT_RUN(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "request stalled with empty output")

  // A new sample traces back to a tick, through the read stage and the sample register
  `WTO_ASSERT_RUN(a_sample_from_tick, clk, rst_n, $rose(out_valid) |-> $past(tick_beat, 2), "sample without a tick")

endmodule

bind wavetable_oscillator wto_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wto_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_sample  (out_ch.sample)
);

`default_nettype wire
